/* hdl/uss_pkg.sv */
// Shared types, constants and helpers for the UTF-8 stream sanitizer.
// No dependencies; every other file imports this package.
package uss_pkg;

    localparam logic OP_FEED  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int JOB_FIFO_DEPTH = 4;
    localparam int JOB_PTR_W      = $clog2(JOB_FIFO_DEPTH);

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VALUE = 8'h80;

    localparam logic [7:0] REPL_B0 = 8'hEF;
    localparam logic [7:0] REPL_B1 = 8'hBF;
    localparam logic [7:0] REPL_B2 = 8'hBD;

    // One unit of output work: rep_cnt U+FFFD sequences, then byte_cnt raw bytes.
    typedef struct packed {
        logic [2:0]      rep_cnt;
        logic [2:0]      byte_cnt;
        logic [3:0][7:0] bytes;
    } t_job;

    function automatic logic [2:0] seq_length(input logic [7:0] lead);
        logic [2:0] len;
        len = 3'd1;
        if (lead[7:5] == 3'b110) len = 3'd2;
        else if (lead[7:4] == 4'b1110) len = 3'd3;
        else if (lead[7:3] == 5'b11110) len = 3'd4;
        return len;
    endfunction

    function automatic logic [7:0] repl_byte(input logic [1:0] k);
        logic [7:0] b;
        unique case (k)
            2'd0:    b = REPL_B0;
            2'd1:    b = REPL_B1;
            default: b = REPL_B2;
        endcase
        return b;
    endfunction

endpackage

/* hdl/uss_stream_if.sv */
// Valid/ready stream interfaces for the sanitizer input and output channels.
// Depends on uss_pkg.
interface uss_in_if
    import uss_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output data_byte, input ready);
    modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface uss_out_if
    import uss_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

/* hdl/uss_front.sv */
// Front end: accepts input transactions, tracks the open sequence and
// classifies each transaction into an output job. Depends on uss_pkg.
module uss_front
    import uss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_operation,
    input  logic [7:0] i_data_byte,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_job       o_job
);

    logic [1:0]      r_count;
    logic [1:0]      n_count;
    logic [7:0]      r_pend [3];

    logic            w_acc;
    logic            w_is_cont;
    logic [2:0]      w_len;
    logic [2:0]      w_count_p1;
    logic            w_complete;
    logic [7:0]      w_c1;
    logic [7:0]      w_c2;
    logic [20:0]     w_cp;
    logic            w_seq_ok;
    logic            w_store_lead;
    t_job            w_job;

    assign o_ready    = !i_full;
    assign w_acc      = i_valid && !i_full;
    assign w_is_cont  = (i_data_byte & CONT_MASK) == CONT_VALUE;
    assign w_len      = seq_length(r_pend[0]);
    assign w_count_p1 = {1'b0, r_count} + 3'd1;
    assign w_complete = w_count_p1 >= w_len;

    // Sequence as it would stand with the incoming byte appended.
    assign w_c1 = (r_count == 2'd1) ? i_data_byte : r_pend[1];
    assign w_c2 = (r_count == 2'd2) ? i_data_byte : r_pend[2];

    always_comb begin
        unique case (w_len)
            3'd2:    w_cp = {10'd0, r_pend[0][4:0], w_c1[5:0]};
            3'd3:    w_cp = {5'd0, r_pend[0][3:0], w_c1[5:0], w_c2[5:0]};
            default: w_cp = {r_pend[0][2:0], w_c1[5:0], w_c2[5:0], i_data_byte[5:0]};
        endcase
        unique case (w_len)
            3'd2:    w_seq_ok = w_cp >= 21'h80;
            3'd3:    w_seq_ok = (w_cp >= 21'h800) && ((w_cp < 21'hD800) || (w_cp > 21'hDFFF));
            default: w_seq_ok = (w_cp >= 21'h10000) && (w_cp <= 21'h10FFFF);
        endcase
    end

    always_comb begin
        w_job          = '0;
        w_job.bytes[0] = r_pend[0];
        w_job.bytes[1] = w_c1;
        w_job.bytes[2] = w_c2;
        w_job.bytes[3] = i_data_byte;
        n_count        = r_count;
        w_store_lead   = 1'b0;
        priority if (i_operation == OP_FLUSH) begin
            w_job.rep_cnt = {1'b0, r_count};
            n_count       = 2'd0;
        end else if (r_count != 2'd0 && w_is_cont) begin
            if (!w_complete) begin
                n_count = r_count + 2'd1;
            end else begin
                if (w_seq_ok) w_job.byte_cnt = w_len;
                else          w_job.rep_cnt  = w_count_p1;
                n_count = 2'd0;
            end
        end else begin
            w_job.rep_cnt = {1'b0, r_count};
            n_count       = 2'd0;
            priority if (i_data_byte == 8'h00) begin
                w_job.rep_cnt = w_job.rep_cnt + 3'd1;
            end else if (!i_data_byte[7]) begin
                w_job.bytes[0] = i_data_byte;
                w_job.byte_cnt = 3'd1;
            end else if (seq_length(i_data_byte) == 3'd1) begin
                w_job.rep_cnt = w_job.rep_cnt + 3'd1;
            end else begin
                w_store_lead = 1'b1;
                n_count      = 2'd1;
            end
        end
    end

    assign o_job  = w_job;
    assign o_push = w_acc && ((w_job.rep_cnt != 3'd0) || (w_job.byte_cnt != 3'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // Pending bytes hold no reset; an entry is only read once written.
    always_ff @(posedge i_clk) begin
        if (w_acc && i_operation == OP_FEED) begin
            if (w_store_lead) r_pend[0] <= i_data_byte;
            if (r_count == 2'd1 && w_is_cont && !w_complete) r_pend[1] <= i_data_byte;
            if (r_count == 2'd2 && w_is_cont && !w_complete) r_pend[2] <= i_data_byte;
        end
    end

endmodule

/* hdl/uss_job_fifo.sv */
// Short job queue that decouples the front end from the output expander.
// Depends on uss_pkg.
module uss_job_fifo
    import uss_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_head
);

    t_job                 r_mem [JOB_FIFO_DEPTH];
    logic [JOB_PTR_W-1:0] r_wr;
    logic [JOB_PTR_W-1:0] r_rd;
    logic [JOB_PTR_W:0]   r_cnt;

    assign o_full  = r_cnt == (JOB_PTR_W+1)'(JOB_FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + JOB_PTR_W'(1);
            if (i_pop)  r_rd <= r_rd + JOB_PTR_W'(1);
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (JOB_PTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (JOB_PTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_job;
    end

endmodule

/* hdl/uss_back.sv */
// Back end: expands one job at a time into output bytes, one per cycle while
// the output is ready, through a registered output stage. Depends on uss_pkg.
module uss_back
    import uss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_valid,
    input  t_job       i_job,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic            r_act;
    logic [2:0]      r_rep_left;
    logic [1:0]      r_k;
    logic [1:0]      r_pos;
    logic [2:0]      r_cnt;
    logic [3:0][7:0] r_bytes;
    logic            r_ov;
    logic [7:0]      r_ob;
    logic            r_ol;

    logic            w_in_rep;
    logic [7:0]      w_byte;
    logic            w_last;
    logic            w_emit;
    logic            w_load;

    assign w_in_rep = r_rep_left != 3'd0;
    assign w_byte   = w_in_rep ? repl_byte(r_k) : r_bytes[r_pos];
    assign w_last   = w_in_rep ? (r_rep_left == 3'd1 && r_k == 2'd2 && r_cnt == 3'd0)
                               : ({1'b0, r_pos} == r_cnt - 3'd1);
    assign w_emit   = r_act && (!r_ov || i_ready);
    // Chain the next job in the cycle the current one ends.
    assign w_load   = i_job_valid && (!r_act || (w_emit && w_last));
    assign o_pop    = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (w_load)               r_act <= 1'b1;
            else if (w_emit && w_last) r_act <= 1'b0;
            if (w_emit)       r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rep_left <= i_job.rep_cnt;
            r_cnt      <= i_job.byte_cnt;
            r_bytes    <= i_job.bytes;
            r_k        <= 2'd0;
            r_pos      <= 2'd0;
        end else if (w_emit) begin
            if (w_in_rep) begin
                if (r_k == 2'd2) begin
                    r_k        <= 2'd0;
                    r_rep_left <= r_rep_left - 3'd1;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end else begin
                r_pos <= r_pos + 2'd1;
            end
        end
        if (w_emit) begin
            r_ob <= w_byte;
            r_ol <= w_last;
        end
    end

    assign o_valid    = r_ov;
    assign o_out_byte = r_ob;
    assign o_last     = r_ol;

endmodule

/* hdl/utf8_stream_sanitizer_unit.sv */
// UTF-8 stream sanitizer top level: front end, job queue, output expander.
// Inputs reach the output via the job queue, the expander's job registers
// and the output register. Throughput: one input transaction per cycle
// while each yields at most one byte, and one output byte per cycle, while
// the output is ready; an item yields up to 12 bytes. Reset is synchronous,
// active-low, clears pending count, queue, output valid; no clearing pass.
module utf8_stream_sanitizer_unit
    import uss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    uss_in_if.sink     i_in,
    uss_out_if.source  o_out
);

    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_fifo_valid;
    t_job w_job;
    t_job w_head;

    uss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .i_operation (i_in.operation),
        .i_data_byte (i_in.data_byte),
        .i_full      (w_full),
        .o_ready     (i_in.ready),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    uss_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_fifo_valid),
        .o_head  (w_head)
    );

    uss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_fifo_valid),
        .i_job       (w_head),
        .o_pop       (w_pop),
        .i_ready     (o_out.ready),
        .o_valid     (o_out.valid),
        .o_out_byte  (o_out.out_byte),
        .o_last      (o_out.last)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_fifo_valid)
        else $error("job popped from empty queue");

    a_job_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_head.rep_cnt != 3'd0 || w_head.byte_cnt != 3'd0))
        else $error("empty job reached the expander");
`endif

endmodule
